### hdl/lir_pkg.sv
// Package for the linear interpolation resampler: widths, rate constants,
// divider constants and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package lir_pkg;

  // Output rate and the derived minimum source step.
  localparam int OUT_RATE    = 16000;
  localparam int RATE_FLOOR  = (OUT_RATE + 1) / 2;

  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 16;
  localparam int POS_W       = 17;
  localparam int FRAC_W      = 14;   // holds any weight below OUT_RATE
  localparam int RATE_RESET  = 15625;

  localparam int MAX_RESULTS = 4;
  localparam int CNT_W       = 3;

  // Divide by OUT_RATE = 2^OUT_SHIFT * OUT_ODD: shift, then reciprocal
  // multiply by 1/OUT_ODD with a single correction step.
  localparam int OUT_SHIFT   = 7;
  localparam int OUT_ODD     = OUT_RATE >> OUT_SHIFT;
  localparam int SUM_W       = 32;
  localparam int MAG_W       = 22;   // |sum| >> OUT_SHIFT
  localparam int QUO_W       = 17;
  localparam int RECIP_K     = 30;
  localparam int RECIP_M     = (1 << RECIP_K) / OUT_ODD;
  localparam int RECIP_W     = 24;
  localparam int PIPE_DEPTH  = 5;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic [RATE_W-1:0]          rate_t;
  typedef logic [POS_W-1:0]           pos_t;

  // Controller -> datapath.
  typedef struct packed {
    logic load;       // take input item
    logic have;       // a sample was already held at load
    logic set_final;  // final interval: current = next = item sample
    logic start;      // launch one blend at the current position
    logic wrap;       // close an interval: position -= OUT_RATE
    logic send_out;   // move finished blend to the output register
    logic run_last;
    logic stream_end;
    logic clr_state;  // end of stream: clear position and held sample
  } lir_cmd_t;

  // Datapath -> controller.
  typedef struct packed {
    logic pos_lt;     // position below OUT_RATE
    logic done;       // blend result ready
    logic out_busy;   // output register holds an untaken result
  } lir_stat_t;

endpackage

`default_nettype wire

### hdl/lir_ifs.sv
// Stream interfaces of the resampler: input, result and configuration
// channels. Depends on lir_pkg.
`default_nettype none

interface lir_in_if;
  logic              valid;
  logic              ready;
  lir_pkg::sample_t  in_sample;
  logic              last_sample;
  modport source (output valid, in_sample, last_sample, input ready);
  modport sink   (input valid, in_sample, last_sample, output ready);
endinterface

interface lir_out_if;
  logic              valid;
  logic              ready;
  lir_pkg::sample_t  out_sample;
  logic              run_last;
  logic              stream_end;
  modport source (output valid, out_sample, run_last, stream_end, input ready);
  modport sink   (input valid, out_sample, run_last, stream_end, output ready);
endinterface

interface lir_cfg_if;
  logic            valid;
  logic            ready;
  lir_pkg::rate_t  rate_value;
  modport source (output valid, rate_value, input ready);
  modport sink   (input valid, rate_value, output ready);
endinterface

`default_nettype wire

### hdl/lir_dp.sv
// Resampler datapath: rate register, held sample, position, blend pipeline
// (multiply-add and divide by OUT_RATE) and the output register.
// Depends on lir_pkg.
`default_nettype none

module lir_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire lir_pkg::lir_cmd_t  cmd,
  output lir_pkg::lir_stat_t      stat,
  input  wire lir_pkg::sample_t   item_sample,
  input  wire logic               cfg_we,
  input  wire lir_pkg::rate_t     cfg_rate,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output lir_pkg::sample_t        out_sample,
  output logic                    out_run_last,
  output logic                    out_stream_end
);

  lir_pkg::rate_t   rate_r;
  lir_pkg::pos_t    pos_r;
  lir_pkg::sample_t held_r;
  lir_pkg::sample_t cur_r;
  lir_pkg::sample_t nxt_r;
  lir_pkg::pos_t    step;

  // blend pipeline
  logic [lir_pkg::FRAC_W-1:0]        f_r;
  logic signed [lir_pkg::SAMPLE_W:0] diff_r;
  lir_pkg::sample_t                  base_r;
  lir_pkg::sample_t                  base1_r;
  logic signed [lir_pkg::SUM_W-1:0]  prod_nxt;
  logic signed [lir_pkg::SUM_W-1:0]  prod_r;
  logic signed [lir_pkg::SUM_W-1:0]  sum_nxt;
  logic signed [lir_pkg::SUM_W-1:0]  sum_r;
  logic [lir_pkg::SUM_W-1:0]         mag;
  logic [lir_pkg::MAG_W-1:0]         b_r;
  logic [lir_pkg::MAG_W-1:0]         b2_r;
  logic                              neg_r;
  logic                              neg2_r;
  logic [lir_pkg::MAG_W+lir_pkg::RECIP_W-1:0] recip_prod;
  logic [lir_pkg::QUO_W-1:0]         q0_r;
  logic [lir_pkg::MAG_W-1:0]         rem;
  logic [lir_pkg::QUO_W-1:0]         quo;
  logic [lir_pkg::QUO_W-1:0]         sres;
  lir_pkg::sample_t                  res_r;
  logic [lir_pkg::PIPE_DEPTH-1:0]    vld_r;

  lir_pkg::sample_t out_sample_r;
  logic             out_valid_r;
  logic             out_rl_r;
  logic             out_se_r;

  assign step = (rate_r < lir_pkg::RATE_W'(lir_pkg::RATE_FLOOR))
              ? lir_pkg::POS_W'(lir_pkg::RATE_FLOOR)
              : lir_pkg::POS_W'(rate_r);

  assign stat.pos_lt   = pos_r < lir_pkg::POS_W'(lir_pkg::OUT_RATE);
  assign stat.done     = vld_r[lir_pkg::PIPE_DEPTH-1];
  assign stat.out_busy = out_valid_r;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r      <= lir_pkg::RATE_W'(lir_pkg::RATE_RESET);
      pos_r       <= '0;
      held_r      <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        rate_r <= cfg_rate;
      end
      if (cmd.load) begin
        held_r <= item_sample;
        if (!cmd.have) begin
          pos_r <= '0;
        end
      end
      if (cmd.start) begin
        pos_r <= pos_r + step;
      end
      if (cmd.wrap) begin
        pos_r <= pos_r - lir_pkg::POS_W'(lir_pkg::OUT_RATE);
      end
      if (cmd.clr_state) begin
        pos_r  <= '0;
        held_r <= '0;
      end
      vld_r <= {vld_r[lir_pkg::PIPE_DEPTH-2:0], cmd.start};
      if (cmd.send_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Interval endpoints
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_r <= cmd.have ? held_r : item_sample;
      nxt_r <= item_sample;
    end else if (cmd.set_final) begin
      cur_r <= nxt_r;
    end
  end

  // Blend: cur*OUT_RATE + (nxt-cur)*f, then signed divide by OUT_RATE
  assign prod_nxt = diff_r * $signed({1'b0, f_r});
  assign sum_nxt  = (lir_pkg::SUM_W'(base1_r) * lir_pkg::SUM_W'(lir_pkg::OUT_RATE))
                  + prod_r;
  assign mag      = sum_r[lir_pkg::SUM_W-1] ? lir_pkg::SUM_W'(-sum_r)
                                            : lir_pkg::SUM_W'(sum_r);
  assign recip_prod = (lir_pkg::MAG_W+lir_pkg::RECIP_W)'(b_r)
                    * (lir_pkg::MAG_W+lir_pkg::RECIP_W)'(lir_pkg::RECIP_M);
  // q0 may be one short; one compare fixes it
  assign rem  = b2_r - lir_pkg::MAG_W'(lir_pkg::MAG_W'(q0_r)
                                       * lir_pkg::MAG_W'(lir_pkg::OUT_ODD));
  assign quo  = (rem >= lir_pkg::MAG_W'(lir_pkg::OUT_ODD)) ? q0_r + 1'b1 : q0_r;
  assign sres = neg2_r ? -quo : quo;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      f_r    <= pos_r[lir_pkg::FRAC_W-1:0];
      diff_r <= {nxt_r[lir_pkg::SAMPLE_W-1], nxt_r} - {cur_r[lir_pkg::SAMPLE_W-1], cur_r};
      base_r <= cur_r;
    end
    prod_r  <= prod_nxt;
    base1_r <= base_r;
    sum_r   <= sum_nxt;
    b_r     <= mag[lir_pkg::OUT_SHIFT +: lir_pkg::MAG_W];
    neg_r   <= sum_r[lir_pkg::SUM_W-1];
    q0_r    <= recip_prod[lir_pkg::RECIP_K +: lir_pkg::QUO_W];
    b2_r    <= b_r;
    neg2_r  <= neg_r;
    if (vld_r[lir_pkg::PIPE_DEPTH-1]) begin
      res_r <= sres[lir_pkg::SAMPLE_W-1:0];
    end
    if (cmd.send_out) begin
      out_sample_r <= res_r;
      out_rl_r     <= cmd.run_last;
      out_se_r     <= cmd.stream_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample     = out_sample_r;
  assign out_run_last   = out_rl_r;
  assign out_stream_end = out_se_r;

endmodule

`default_nettype wire

### hdl/lir_ctrl.sv
// Resampler controller: walks the source intervals of one item, launches
// blends, and tags and releases results. Depends on lir_pkg.
`default_nettype none

module lir_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic                item_last,
  input  wire lir_pkg::lir_stat_t  stat,
  output lir_pkg::lir_cmd_t        cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_CALC,
    S_FINISH
  } state_t;

  state_t                    state_r, state_nxt;
  logic                      have_first_r, have_first_nxt;
  logic                      last_r, last_nxt;
  logic                      final_ph_r, final_ph_nxt;
  logic                      pend_r, pend_nxt;
  logic [lir_pkg::CNT_W-1:0] n_r, n_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    have_first_nxt = have_first_r;
    last_nxt       = last_r;
    final_ph_nxt   = final_ph_r;
    pend_nxt       = pend_r;
    n_nxt          = n_r;
    cmd            = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load     = 1'b1;
          cmd.have     = have_first_r;
          last_nxt     = item_last;
          n_nxt        = '0;
          final_ph_nxt = !have_first_r;
          if (have_first_r || item_last) begin
            state_nxt = S_CHECK;
          end
          have_first_nxt = 1'b1;
        end
      end
      S_CHECK: begin
        if (stat.pos_lt && (n_r < lir_pkg::CNT_W'(lir_pkg::MAX_RESULTS))) begin
          if (!(pend_r && stat.out_busy)) begin
            cmd.start    = 1'b1;
            cmd.send_out = pend_r;
            pend_nxt     = 1'b0;
            n_nxt        = n_r + 1'b1;
            state_nxt    = S_CALC;
          end
        end else begin
          cmd.wrap = 1'b1;
          if (!final_ph_r && last_r) begin
            cmd.set_final = 1'b1;
            final_ph_nxt  = 1'b1;
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_CALC: begin
        if (stat.done) begin
          pend_nxt  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_FINISH: begin
        if (!(pend_r && stat.out_busy)) begin
          cmd.send_out   = pend_r;
          cmd.run_last   = 1'b1;
          cmd.stream_end = last_r;
          pend_nxt       = 1'b0;
          if (last_r) begin
            cmd.clr_state  = 1'b1;
            have_first_nxt = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      have_first_r <= 1'b0;
      last_r       <= 1'b0;
      final_ph_r   <= 1'b0;
      pend_r       <= 1'b0;
      n_r          <= '0;
    end else begin
      state_r      <= state_nxt;
      have_first_r <= have_first_nxt;
      last_r       <= last_nxt;
      final_ph_r   <= final_ph_nxt;
      pend_r       <= pend_nxt;
      n_r          <= n_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/linear_interp_resampler.sv
// Top level of the linear interpolation resampler: controller plus datapath.
// Depends on lir_pkg, lir_ifs (interfaces), lir_ctrl and lir_dp.
//
//  channel  | dir | payload                               | transfer
//  ---------+-----+---------------------------------------+------------------
//  in_ch    | in  | in_sample (s16), last_sample          | valid && ready
//  out_ch   | out | out_sample (s16), run_last, stream_end| valid && ready
//  cfg_ch   | in  | rate_value (u16)                      | valid (ready = 1)
//
// One item at a time. An item is accepted, then each result is launched
// and passes through the multiply/divide pipeline, each interval is closed
// and the item finishes; a final item that follows an earlier sample closes
// two intervals. A first sample that is not final is only accepted.
// Synchronous active-low reset; no clearing pass. A result waiting in the
// output register holds off the next result launch only while a finished
// result is also pending; it can wait there while the next one is computed.
`default_nettype none

module linear_interp_resampler (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lir_in_if.sink     in_ch,
  lir_out_if.source  out_ch,
  lir_cfg_if.sink    cfg_ch
);

  lir_pkg::lir_cmd_t  cmd;
  lir_pkg::lir_stat_t stat;
  logic               in_ready;

  // config register is always writable
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  lir_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .item_last (in_ch.last_sample),
    .stat      (stat),
    .cmd       (cmd)
  );

  lir_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .item_sample    (in_ch.in_sample),
    .cfg_we         (cfg_ch.valid),
    .cfg_rate       (cfg_ch.rate_value),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_sample     (out_ch.out_sample),
    .out_run_last   (out_ch.run_last),
    .out_stream_end (out_ch.stream_end)
  );

endmodule

`default_nettype wire
